// ----- hdl/pkmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel key and mode controller package
// Shared types, codes and the next-allowed-bit function.
// ----------------------------------------------------------------------------
package pkmc_pkg;

   localparam int NUM_MODES   = 5;
   localparam int NUM_SENSORS = 6;
   localparam int FAN_W       = 3;
   localparam int TEMP_W      = 6;
   localparam int HUM_W       = 7;
   localparam int FUNC_W      = 3;
   localparam int ERR_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 6;
   localparam int SEARCH_W    = 16;

   localparam logic [NUM_SENSORS-1:0] HUM_SENSORS = 6'b111000;
   localparam logic [HUM_W-1:0]       HUM_LIMIT   = 7'd100;

   // Key codes.
   localparam logic [FUNC_W-1:0] FUNC_MODE     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SENSOR   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_FAN      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_FAN_LONG = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DOWN     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_UP       = 3'd5;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_MODES   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOWED_SENSORS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAN_SPEED   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SET_MIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_SET_MAX    = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ERR_W-1:0]  error_flags;
   } req_payload_type;

   typedef struct packed {
      logic [NUM_MODES-1:0]   mode_onehot;
      logic [NUM_SENSORS-1:0] sensor_onehot;
      logic [FAN_W-1:0]       fan_level;
      logic                   running;
      logic [TEMP_W-1:0]      temp_target;
      logic [HUM_W-1:0]       hum_target;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_MODES-1:0]   allowed_modes;
      logic [NUM_SENSORS-1:0] allowed_sensors;
      logic [FAN_W-1:0]       max_fan_speed;
      logic [TEMP_W-1:0]      temp_set_min;
      logic [TEMP_W-1:0]      temp_set_max;
   } cfg_type;

   // Next allowed bit strictly above the highest set bit of cur, wrapping to
   // the lowest allowed bit. A zero cur gives the lowest allowed bit.
   function automatic logic [SEARCH_W-1:0] next_bit(input logic [SEARCH_W-1:0] cur,
                                                    input logic [SEARCH_W-1:0] allow);
      logic [SEARCH_W-1:0] above;
      logic [SEARCH_W-1:0] cand;
      for (int i = 0; i < SEARCH_W; i++) begin
         above[i] = ((cur >> i) == '0);
      end
      cand = allow & above;
      if (cand != '0) begin
         return cand & (~cand + 1'b1);
      end
      return allow & (~allow + 1'b1);
   endfunction

endpackage

// ----- hdl/pkmc_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel key and mode controller configuration registers
// Holds the five writable settings; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module pkmc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pkmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pkmc_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output pkmc_pkg::cfg_type                    cfg
);

   pkmc_pkg::cfg_type cfg_ff;
   pkmc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pkmc_pkg::CSR_ALLOWED_MODES: begin
               cfg_in.allowed_modes = csr_wr_data[pkmc_pkg::NUM_MODES-1:0];
            end
            pkmc_pkg::CSR_ALLOWED_SENSORS: begin
               cfg_in.allowed_sensors = csr_wr_data[pkmc_pkg::NUM_SENSORS-1:0];
            end
            pkmc_pkg::CSR_MAX_FAN_SPEED: begin
               cfg_in.max_fan_speed = csr_wr_data[pkmc_pkg::FAN_W-1:0];
            end
            pkmc_pkg::CSR_TEMP_SET_MIN: begin
               cfg_in.temp_set_min = csr_wr_data[pkmc_pkg::TEMP_W-1:0];
            end
            pkmc_pkg::CSR_TEMP_SET_MAX: begin
               cfg_in.temp_set_max = csr_wr_data[pkmc_pkg::TEMP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allowed_modes   <= '1;
         cfg_ff.allowed_sensors <= '1;
         cfg_ff.max_fan_speed   <= '1;
         cfg_ff.temp_set_min    <= '0;
         cfg_ff.temp_set_max    <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/pkmc_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel key and mode controller state update
// Works out the panel state that follows one key event.
// ----------------------------------------------------------------------------
module pkmc_update (
   input  pkmc_pkg::cfg_type          cfg,
   input  pkmc_pkg::rsp_payload_type  cur,
   input  pkmc_pkg::req_payload_type  key,
   output pkmc_pkg::rsp_payload_type  nxt
);

   logic [pkmc_pkg::SEARCH_W-1:0] mode_next;
   logic [pkmc_pkg::SEARCH_W-1:0] sensor_next;
   logic                          no_error;
   logic                          hum_selected;

   assign mode_next = pkmc_pkg::next_bit(
      {{(pkmc_pkg::SEARCH_W-pkmc_pkg::NUM_MODES){1'b0}}, cur.mode_onehot},
      {{(pkmc_pkg::SEARCH_W-pkmc_pkg::NUM_MODES){1'b0}}, cfg.allowed_modes});
   assign sensor_next = pkmc_pkg::next_bit(
      {{(pkmc_pkg::SEARCH_W-pkmc_pkg::NUM_SENSORS){1'b0}}, cur.sensor_onehot},
      {{(pkmc_pkg::SEARCH_W-pkmc_pkg::NUM_SENSORS){1'b0}}, cfg.allowed_sensors});
   assign no_error     = (key.error_flags == '0);
   assign hum_selected = ((cur.sensor_onehot & pkmc_pkg::HUM_SENSORS) != '0);

   always_comb begin
      nxt = cur;
      case (key.func)
         pkmc_pkg::FUNC_MODE: begin
            // An empty mask leaves the search result at zero, clearing the mode.
            nxt.mode_onehot = mode_next[pkmc_pkg::NUM_MODES-1:0];
         end
         pkmc_pkg::FUNC_SENSOR: begin
            if (cfg.allowed_sensors == '0) begin
               nxt.sensor_onehot = {{(pkmc_pkg::NUM_SENSORS-1){1'b0}}, 1'b1};
            end else begin
               nxt.sensor_onehot = sensor_next[pkmc_pkg::NUM_SENSORS-1:0];
            end
         end
         pkmc_pkg::FUNC_FAN: begin
            if (no_error) begin
               if (!cur.running) begin
                  nxt.running = 1'b1;
               end else if (cur.fan_level < cfg.max_fan_speed) begin
                  nxt.fan_level = cur.fan_level + 1'b1;
               end else begin
                  nxt.fan_level = {{(pkmc_pkg::FAN_W-1){1'b0}}, 1'b1};
               end
            end
         end
         pkmc_pkg::FUNC_FAN_LONG: begin
            if (no_error) begin
               nxt.running = 1'b0;
            end
         end
         pkmc_pkg::FUNC_DOWN: begin
            if (hum_selected) begin
               if (cur.hum_target != '0) begin
                  nxt.hum_target = cur.hum_target - 1'b1;
               end
            end else if (cur.temp_target > cfg.temp_set_min) begin
               nxt.temp_target = cur.temp_target - 1'b1;
            end
         end
         pkmc_pkg::FUNC_UP: begin
            if (hum_selected) begin
               if (cur.hum_target < pkmc_pkg::HUM_LIMIT) begin
                  nxt.hum_target = cur.hum_target + 1'b1;
               end
            end else if (cur.temp_target < cfg.temp_set_max) begin
               nxt.temp_target = cur.temp_target + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hdl/panel_key_mode_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel key and mode controller
// Keeps the panel state (mode, sensor, fan, setpoints) from a stream of key
// events and reports the whole state after every event.
// ----------------------------------------------------------------------------
//   Channel   Direction  Contents
//   req_*     in         one key event: func, error_flags (valid/ready)
//   rsp_*     out        panel state after that event (valid/ready)
//   csr_*     in         register write: enable, index, data (no wait)
//
// One request is taken in every cycle while the result side keeps up; an
// accepted request passes from the input register into the state register,
// which doubles as the result register, and is offered there as a response.
// Reset is synchronous and restores the register defaults and the initial
// panel state. A stalled response holds the state stage; the input register
// still takes a request if it is empty, after which req_ready falls.
// ----------------------------------------------------------------------------
module panel_key_mode_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pkmc_pkg::req_payload_type          req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pkmc_pkg::rsp_payload_type          rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [pkmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pkmc_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   pkmc_pkg::cfg_type          cfg;
   pkmc_pkg::req_payload_type  key_ff;
   logic                       key_valid_ff;
   pkmc_pkg::rsp_payload_type  state_ff;
   pkmc_pkg::rsp_payload_type  state_in;
   logic                       rsp_valid_ff;
   logic                       advance;

   pkmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pkmc_update u_update (
      .cfg (cfg),
      .cur (state_ff),
      .key (key_ff),
      .nxt (state_in)
   );

   // The state stage moves on when the held request can leave as a response,
   // that is when the result register is empty or being emptied this cycle.
   assign advance   = key_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !key_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= 1'b0;
      end else if (req_ready) begin
         key_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         key_ff <= req_payload;
      end
   end

   // The panel state is the result register: it only changes on reset or when a
   // new response is loaded, so it always equals the response on offer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode_onehot   <= '0;
         state_ff.sensor_onehot <= {{(pkmc_pkg::NUM_SENSORS-1){1'b0}}, 1'b1};
         state_ff.fan_level     <= '0;
         state_ff.running       <= 1'b0;
         state_ff.temp_target   <= '0;
         state_ff.hum_target    <= '0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = state_ff;

endmodule
